// File: rtl/core/afth_pkg.sv
// Shared types, constants and the control-store program for the fitness threshold block.
`timescale 1ns / 1ps
`default_nettype none
package afth_pkg;

    localparam int FIT_W      = 24;
    localparam int CNT_W      = 11;
    localparam int SUM_W      = 34;
    localparam int SQ_W       = 57;
    localparam int PROD_W     = 48;
    localparam int WIDE_W     = 67;
    localparam int VAR_W      = 48;
    localparam int ROOT_W     = 24;
    localparam int DEV_W      = 23;
    localparam int LEVEL_W    = 2;
    localparam int LOOP_W     = 7;
    localparam int STEP_W     = 4;
    localparam int DIV_R_W    = 2 * CNT_W;
    localparam int SQRT_R_W   = ROOT_W + 3;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 128;

    localparam logic [CNT_W-1:0]  MAX_SAMPLES = CNT_W'(1024);
    localparam logic [FIT_W-1:0]  NEG_LIMIT   = {1'b1, {(FIT_W-1){1'b0}}};

    localparam logic [LOOP_W-1:0] MUL_N_STEPS    = LOOP_W'(CNT_W);
    localparam logic [LOOP_W-1:0] MUL_S_STEPS    = LOOP_W'(SUM_W);
    localparam logic [LOOP_W-1:0] DIV_VAR_STEPS  = LOOP_W'(WIDE_W);
    localparam logic [LOOP_W-1:0] DIV_MEAN_STEPS = LOOP_W'(SUM_W);
    localparam logic [LOOP_W-1:0] SQRT_STEPS     = LOOP_W'(ROOT_W);

    localparam logic KIND_LOAD     = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;
    localparam logic RK_THRESH     = 1'b0;
    localparam logic RK_CLASSIFY   = 1'b1;

    localparam logic [LEVEL_W-1:0] LVL_0 = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_1 = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_2 = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_3 = 2'd3;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_SQUARE,
        OP_ACCUM,
        OP_MUL_N_SETUP,
        OP_MUL_STEP,
        OP_MUL_S_SETUP,
        OP_DIV_VAR_SETUP,
        OP_DIV_STEP,
        OP_DIV_MEAN_SETUP,
        OP_SQRT_SETUP,
        OP_SQRT_STEP,
        OP_TOP,
        OP_FINISH
    } op_t;

    typedef enum logic [1:0] {
        BR_NONE,
        BR_LOOP,
        BR_EXIT_NLAST
    } br_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } seq_state_t;

    typedef struct packed {
        op_t               op;
        br_t               br;
        logic [STEP_W-1:0] target;
        logic              emit;
        logic              finish;
    } ucw_t;

    typedef struct packed {
        logic run;
        op_t  op;
        logic emit;
    } seq_ctl_t;

    typedef struct packed {
        logic             valid;
        logic [FIT_W-1:0] t1;
        logic [FIT_W-1:0] t2;
        logic [FIT_W-1:0] t3;
    } thr_t;

    typedef struct packed {
        logic [FIT_W-1:0] mean;
        logic [FIT_W-1:0] middle;
        logic [FIT_W-1:0] top;
        logic [FIT_W-1:0] largest;
        logic [DEV_W-1:0] deviation;
        logic             overflow;
    } res_t;

    function automatic ucw_t ucode_rom(input logic [STEP_W-1:0] addr);
        ucw_t w;
        w = '{op: OP_NOP, br: BR_NONE, target: '0, emit: 1'b0, finish: 1'b1};
        case (addr)
            STEP_W'(0):  w = '{OP_SQUARE,         BR_NONE,       STEP_W'(0),  1'b0, 1'b0};
            STEP_W'(1):  w = '{OP_ACCUM,          BR_EXIT_NLAST, STEP_W'(0),  1'b0, 1'b0};
            STEP_W'(2):  w = '{OP_MUL_N_SETUP,    BR_NONE,       STEP_W'(0),  1'b0, 1'b0};
            STEP_W'(3):  w = '{OP_MUL_STEP,       BR_LOOP,       STEP_W'(3),  1'b0, 1'b0};
            STEP_W'(4):  w = '{OP_MUL_S_SETUP,    BR_NONE,       STEP_W'(0),  1'b0, 1'b0};
            STEP_W'(5):  w = '{OP_MUL_STEP,       BR_LOOP,       STEP_W'(5),  1'b0, 1'b0};
            STEP_W'(6):  w = '{OP_DIV_VAR_SETUP,  BR_NONE,       STEP_W'(0),  1'b0, 1'b0};
            STEP_W'(7):  w = '{OP_DIV_STEP,       BR_LOOP,       STEP_W'(7),  1'b0, 1'b0};
            STEP_W'(8):  w = '{OP_DIV_MEAN_SETUP, BR_NONE,       STEP_W'(0),  1'b0, 1'b0};
            STEP_W'(9):  w = '{OP_DIV_STEP,       BR_LOOP,       STEP_W'(9),  1'b0, 1'b0};
            STEP_W'(10): w = '{OP_SQRT_SETUP,     BR_NONE,       STEP_W'(0),  1'b0, 1'b0};
            STEP_W'(11): w = '{OP_SQRT_STEP,      BR_LOOP,       STEP_W'(11), 1'b0, 1'b0};
            STEP_W'(12): w = '{OP_TOP,            BR_NONE,       STEP_W'(0),  1'b0, 1'b0};
            STEP_W'(13): w = '{OP_FINISH,         BR_NONE,       STEP_W'(0),  1'b1, 1'b1};
            default:     w = '{OP_NOP,            BR_NONE,       STEP_W'(0),  1'b0, 1'b1};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/afth_sequencer.sv
// Step counter and control-store lookup with loop and exit branches.
`timescale 1ns / 1ps
`default_nettype none
module afth_sequencer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               out_free,
    input  wire logic               cnt_last,
    input  wire logic               item_last,
    output afth_pkg::seq_ctl_t      ctl,
    output logic                    busy
);
    import afth_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    ucw_t              cw;
    logic              run;

    assign cw   = ucode_rom(step_reg);
    // an emitting step holds until the output slot is free
    assign run  = (state_reg == S_RUN) && !(cw.emit && !out_free);
    assign busy = (state_reg == S_RUN);

    assign ctl.run  = run;
    assign ctl.op   = cw.op;
    assign ctl.emit = run && cw.emit;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RUN;
                    step_next  = '0;
                end
            end
            S_RUN:
            begin
                if (run)
                begin
                    if (cw.finish || (cw.br == BR_EXIT_NLAST && !item_last))
                        state_next = S_IDLE;
                    else if (cw.br == BR_LOOP && !cnt_last)
                        step_next = cw.target;
                    else
                        step_next = step_reg + STEP_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/afth_datapath.sv
// Set accumulators and the shared shift/add/subtract unit for products, quotients and root.
`timescale 1ns / 1ps
`default_nettype none
module afth_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire afth_pkg::seq_ctl_t           ctl,
    input  wire logic signed [afth_pkg::FIT_W-1:0] fitness,
    output logic                              cnt_last,
    output afth_pkg::thr_t                    thr,
    output afth_pkg::res_t                    res
);
    import afth_pkg::*;

    // set state
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic signed [FIT_W-1:0] max_reg, max_next;
    logic                    drop_reg, drop_next;
    logic                    thr_valid_reg, thr_valid_next;
    logic [LOOP_W-1:0]       cnt_reg, cnt_next;

    // work registers
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [WIDE_W-1:0]       a_reg, a_next;
    logic [WIDE_W-1:0]       b_reg, b_next;
    logic [WIDE_W-1:0]       q_reg, q_next;
    logic [WIDE_W-1:0]       p_reg, p_next;
    logic                    neg_reg, neg_next;
    logic [VAR_W-1:0]        var_reg, var_next;
    logic [FIT_W-1:0]        mean_reg, mean_next;
    logic [ROOT_W-1:0]       dev_reg, dev_next;
    logic [FIT_W-1:0]        top_reg, top_next;
    logic [FIT_W-1:0]        t1_reg, t1_next;
    logic [FIT_W-1:0]        t2_reg, t2_next;
    logic [FIT_W-1:0]        t3_reg, t3_next;

    logic signed [PROD_W-1:0] square_w;
    logic [SUM_W-1:0]         abs_sum;
    logic [2*CNT_W-1:0]       n_sq;
    logic [WIDE_W:0]          var_diff;
    logic [DIV_R_W-1:0]       div_rem;
    logic [SQRT_R_W-1:0]      sq_rem;
    logic [SQRT_R_W-1:0]      sq_trial;
    logic [FIT_W-1:0]         mean_mag;
    logic [FIT_W:0]           top_wide;
    logic [FIT_W-1:0]         top_sat;
    logic [FIT_W:0]           mid_diff;
    logic [FIT_W:0]           mid_round;
    logic [FIT_W-1:0]         mid_w;

    assign square_w = fitness * fitness;
    assign abs_sum  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign n_sq     = {{CNT_W{1'b0}}, count_reg} * {{CNT_W{1'b0}}, count_reg};
    assign var_diff = {1'b0, p_reg} - {1'b0, a_reg};
    assign div_rem  = {a_reg[DIV_R_W-2:0], q_reg[WIDE_W-1]};
    assign sq_rem   = {a_reg[SQRT_R_W-3:0], q_reg[WIDE_W-1 -: 2]};
    assign sq_trial = {b_reg[ROOT_W:0], 2'b01};
    assign mean_mag = q_reg[FIT_W-1:0];

    // maximum minus deviation, clamped at the most negative value
    assign top_wide = {max_reg[FIT_W-1], max_reg} - {1'b0, b_reg[ROOT_W-1:0]};
    assign top_sat  = (top_wide[FIT_W] && !top_wide[FIT_W-1]) ? NEG_LIMIT
                                                              : top_wide[FIT_W-1:0];

    // mean + (top - mean) / 2, halving toward zero
    assign mid_diff  = {top_reg[FIT_W-1], top_reg} - {mean_reg[FIT_W-1], mean_reg};
    assign mid_round = mid_diff + {{FIT_W{1'b0}}, mid_diff[FIT_W]};
    assign mid_w     = mean_reg + mid_round[FIT_W:1];

    assign cnt_last = (cnt_reg == LOOP_W'(1));

    assign thr.valid = thr_valid_reg;
    assign thr.t1    = t1_reg;
    assign thr.t2    = t2_reg;
    assign thr.t3    = t3_reg;

    assign res.mean      = mean_reg;
    assign res.middle    = mid_w;
    assign res.top       = top_reg;
    assign res.largest   = max_reg;
    assign res.deviation = dev_reg[DEV_W-1:0];
    assign res.overflow  = drop_reg;

    always_comb
    begin
        count_next     = count_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        max_next       = max_reg;
        drop_next      = drop_reg;
        thr_valid_next = thr_valid_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        q_next         = q_reg;
        p_next         = p_reg;
        neg_next       = neg_reg;
        var_next       = var_reg;
        mean_next      = mean_reg;
        dev_next       = dev_reg;
        top_next       = top_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        t3_next        = t3_reg;
        if (ctl.run)
        begin
            case (ctl.op)
                OP_SQUARE:
                begin
                    prod_next = PROD_W'(square_w);
                end
                OP_ACCUM:
                begin
                    if (count_reg < MAX_SAMPLES)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        sum_next   = sum_reg + SUM_W'(fitness);
                        sq_next    = sq_reg + SQ_W'(prod_reg);
                        if (fitness > max_reg)
                            max_next = fitness;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
                OP_MUL_N_SETUP:
                begin
                    a_next   = '0;
                    b_next   = WIDE_W'(sq_reg);
                    q_next   = WIDE_W'(count_reg);
                    cnt_next = MUL_N_STEPS;
                end
                OP_MUL_STEP:
                begin
                    if (q_reg[0])
                        a_next = a_reg + b_reg;
                    b_next   = b_reg << 1;
                    q_next   = q_reg >> 1;
                    cnt_next = cnt_reg - LOOP_W'(1);
                end
                OP_MUL_S_SETUP:
                begin
                    p_next   = a_reg;
                    a_next   = '0;
                    b_next   = WIDE_W'(abs_sum);
                    q_next   = WIDE_W'(abs_sum);
                    cnt_next = MUL_S_STEPS;
                end
                OP_DIV_VAR_SETUP:
                begin
                    neg_next = var_diff[WIDE_W];
                    q_next   = var_diff[WIDE_W-1:0];
                    a_next   = '0;
                    b_next   = WIDE_W'(n_sq);
                    cnt_next = DIV_VAR_STEPS;
                end
                OP_DIV_STEP:
                begin
                    if (div_rem >= b_reg[DIV_R_W-1:0])
                    begin
                        a_next = WIDE_W'(div_rem - b_reg[DIV_R_W-1:0]);
                        q_next = {q_reg[WIDE_W-2:0], 1'b1};
                    end
                    else
                    begin
                        a_next = WIDE_W'(div_rem);
                        q_next = {q_reg[WIDE_W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg - LOOP_W'(1);
                end
                OP_DIV_MEAN_SETUP:
                begin
                    var_next = neg_reg ? '0 : q_reg[VAR_W-1:0];
                    q_next   = {abs_sum, {(WIDE_W-SUM_W){1'b0}}};
                    a_next   = '0;
                    b_next   = WIDE_W'(count_reg);
                    cnt_next = DIV_MEAN_STEPS;
                end
                OP_SQRT_SETUP:
                begin
                    mean_next = sum_reg[SUM_W-1] ? (~mean_mag + FIT_W'(1)) : mean_mag;
                    q_next    = {var_reg, {(WIDE_W-VAR_W){1'b0}}};
                    a_next    = '0;
                    b_next    = '0;
                    cnt_next  = SQRT_STEPS;
                end
                OP_SQRT_STEP:
                begin
                    if (sq_rem >= sq_trial)
                    begin
                        a_next = WIDE_W'(sq_rem - sq_trial);
                        b_next = {b_reg[WIDE_W-2:0], 1'b1};
                    end
                    else
                    begin
                        a_next = WIDE_W'(sq_rem);
                        b_next = {b_reg[WIDE_W-2:0], 1'b0};
                    end
                    q_next   = q_reg << 2;
                    cnt_next = cnt_reg - LOOP_W'(1);
                end
                OP_TOP:
                begin
                    dev_next = b_reg[ROOT_W-1:0];
                    top_next = top_sat;
                end
                OP_FINISH:
                begin
                    t1_next        = mean_reg;
                    t2_next        = mid_w;
                    t3_next        = top_reg;
                    thr_valid_next = 1'b1;
                    count_next     = '0;
                    sum_next       = '0;
                    sq_next        = '0;
                    max_next       = NEG_LIMIT;
                    drop_next      = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            max_reg       <= NEG_LIMIT;
            drop_reg      <= 1'b0;
            thr_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            max_reg       <= max_next;
            drop_reg      <= drop_next;
            thr_valid_reg <= thr_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        q_reg    <= q_next;
        p_reg    <= p_next;
        neg_reg  <= neg_next;
        var_reg  <= var_next;
        mean_reg <= mean_next;
        dev_reg  <= dev_next;
        top_reg  <= top_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        t3_reg   <= t3_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_SAMPLES)
        else $error("sample count beyond capacity");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> (count_reg == MAX_SAMPLES))
        else $error("drop flag set while set not full");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.run && ctl.op == OP_FINISH) |=>
            (count_reg == '0 && !drop_reg && thr_valid_reg))
        else $error("set not cleared after threshold result");

endmodule
`default_nettype wire

// File: rtl/core/adaptive_fitness_thresholds.sv
// Top level: stream ports, classification and the output register.
//
// Input channel s_axis: tuser is the item kind (0 load a fitness sample,
// 1 classify a fitness), tdata the signed fitness with 8 fraction bits,
// tlast marks the sample that closes a set.
// Output channel m_axis: tuser is the result kind (0 threshold set,
// 1 classification level), tdata carries the level or the threshold set.
// Classify: result registered in the cycle after acceptance; one item per
// cycle while the output is taken.
// Load without tlast: acceptance plus two control steps per item.
// Load with tlast: after acceptance, the shared shift/add/subtract unit
// does the two products, the two quotients and the square root one bit
// or one digit per cycle before the result is presented.
// No new item is taken while a set is being closed.
// Reset clears the set accumulators and invalidates the thresholds; until
// the first set closes, every classification returns level 0.
// A stalled receiver holds the result in the output register; the block
// then takes no new item until that result leaves.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_fitness_thresholds (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [afth_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // fitness
    input  wire logic                                 s_axis_tlast,  // last_sample
    input  wire logic                                 s_axis_tuser,  // kind
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // level, mean_threshold, middle_threshold, top_threshold, largest,
    // deviation, overflow, zero pad
    output logic [afth_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    output logic                                      m_axis_tuser   // result_kind
);
    import afth_pkg::*;

    logic                    accept;
    logic                    start;
    logic                    out_free;
    logic                    busy;
    logic                    cnt_last;
    seq_ctl_t                ctl;
    thr_t                    thr;
    res_t                    res;

    logic signed [FIT_W-1:0] fit_reg;
    logic                    last_reg;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_kind_reg, out_kind_next;
    logic [OUT_TDATA_W-1:0]  out_data_reg, out_data_next;

    logic signed [FIT_W-1:0] f_in;
    logic [LEVEL_W-1:0]      lvl;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !busy && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign start         = accept && (s_axis_tuser == KIND_LOAD);
    assign f_in          = $signed(s_axis_tdata[FIT_W-1:0]);

    afth_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .out_free  (out_free),
        .cnt_last  (cnt_last),
        .item_last (last_reg),
        .ctl       (ctl),
        .busy      (busy)
    );

    afth_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .fitness  (fit_reg),
        .cnt_last (cnt_last),
        .thr      (thr),
        .res      (res)
    );

    // first matching band wins; level 0 band starts at one LSB
    always_comb
    begin
        lvl = LVL_0;
        if (thr.valid)
        begin
            if (f_in >= $signed(FIT_W'(1)) && f_in <= $signed(thr.t1))
                lvl = LVL_0;
            else if (f_in >= $signed(thr.t1) && f_in <= $signed(thr.t2))
                lvl = LVL_1;
            else if (f_in >= $signed(thr.t2) && f_in <= $signed(thr.t3))
                lvl = LVL_2;
            else if (f_in >= $signed(thr.t3))
                lvl = LVL_3;
            else
                lvl = LVL_0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        if (out_free)
        begin
            if (ctl.emit)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = RK_THRESH;
                out_data_next  = {6'b0, res.overflow, res.deviation, res.largest,
                                  res.top, res.middle, res.mean, LVL_0};
            end
            else if (accept && s_axis_tuser == KIND_CLASSIFY)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = RK_CLASSIFY;
                out_data_next  = {{(OUT_TDATA_W-LEVEL_W){1'b0}}, lvl};
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
        if (accept)
        begin
            fit_reg  <= f_in;
            last_reg <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_axis_tready)
        else $error("item taken while a program runs");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> out_free)
        else $error("threshold result issued into a full output register");

    a_class_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == RK_CLASSIFY) |->
            (m_axis_tdata[OUT_TDATA_W-1:LEVEL_W] == '0))
        else $error("classification result carries threshold data");

endmodule
`default_nettype wire
